[rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the motor feedback unwrap block.
// No dependencies; pulled in by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_RST(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Check a property on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

[rtl/cmfu_pkg.sv]
// Shared types, constants and register codes of the motor feedback unwrap block.
// No dependencies; used by every module of the block except cmfu_fifo.
package cmfu_pkg;

   localparam int MOTOR_SLOTS_DEFAULT = 8;
   localparam int TURN_BITS_DEFAULT   = 16;

   localparam int ID_W        = 11;
   localparam int MASK_W      = 8;
   localparam int SLOT_W      = 3;
   localparam int BYTE_W      = 8;
   localparam int WORD_W      = 16;
   localparam int POS_W       = 32;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 2;

   // Queue depths, powers of two
   localparam int MID_DEPTH = 2;
   localparam int OUT_DEPTH = 4;

   localparam logic [ID_W-1:0]   BASE_ID_RESET = 11'h201;
   localparam logic [MASK_W-1:0] ENABLE_RESET  = 8'hFF;
   localparam logic [WORD_W-1:0] CPT_RESET     = 16'd8191;
   localparam logic [WORD_W-1:0] WRAP_RESET    = 16'd4096;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BASE_ID = 2'd0,
      CSR_ENABLE  = 2'd1,
      CSR_CPT     = 2'd2,
      CSR_WRAP    = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [ID_W-1:0]   motor_base_id;
      logic [MASK_W-1:0] motor_enable_mask;
      logic [WORD_W-1:0] counts_per_turn;
      logic [WORD_W-1:0] wrap_threshold;
   } csr_type;

   typedef struct packed {
      logic [ID_W-1:0]   frame_id;
      logic [BYTE_W-1:0] byte_zero;
      logic [BYTE_W-1:0] byte_one;
      logic [BYTE_W-1:0] byte_two;
      logic [BYTE_W-1:0] byte_three;
      logic [BYTE_W-1:0] byte_four;
      logic [BYTE_W-1:0] byte_five;
      logic [BYTE_W-1:0] byte_six;
   } req_frame_type;

   // Classified request as it waits between front and back
   typedef struct packed {
      logic                     hit;
      logic [SLOT_W-1:0]        slot;
      logic [WORD_W-1:0]        angle;
      logic signed [WORD_W-1:0] speed;
      logic signed [WORD_W-1:0] current;
      logic [BYTE_W-1:0]        temperature;
   } mid_item_type;

   typedef struct packed {
      logic                     hit;
      logic [SLOT_W-1:0]        motor_slot;
      logic signed [POS_W-1:0]  position_count;
      logic signed [WORD_W-1:0] speed_raw;
      logic signed [WORD_W-1:0] current_raw;
      logic [BYTE_W-1:0]        temperature;
   } rsp_item_type;

endpackage

[rtl/can_motor_feedback_unwrap_core.sv]
// Motor feedback unwrap: one request per cycle is sustained while results are
// popped as they arrive; the rate is set by the back end's three-step pipeline
// (turn update, multiply, saturate) and its 4-entry result queue.
// Reset is synchronous: queues empty, per-slot turn state cleared, registers reloaded.
// Depends on cmfu_pkg, cmfu_fifo, cmfu_front, cmfu_back and assert_macros.svh.
`include "assert_macros.svh"

module can_motor_feedback_unwrap_core #(
   parameter int MOTOR_SLOTS = cmfu_pkg::MOTOR_SLOTS_DEFAULT,
   parameter int TURN_BITS   = cmfu_pkg::TURN_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [cmfu_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [cmfu_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  logic                                  push,
   output logic                                  full,
   input  logic [cmfu_pkg::ID_W-1:0]             req_frame_id,
   input  logic [cmfu_pkg::BYTE_W-1:0]           req_byte_zero,
   input  logic [cmfu_pkg::BYTE_W-1:0]           req_byte_one,
   input  logic [cmfu_pkg::BYTE_W-1:0]           req_byte_two,
   input  logic [cmfu_pkg::BYTE_W-1:0]           req_byte_three,
   input  logic [cmfu_pkg::BYTE_W-1:0]           req_byte_four,
   input  logic [cmfu_pkg::BYTE_W-1:0]           req_byte_five,
   input  logic [cmfu_pkg::BYTE_W-1:0]           req_byte_six,
   output logic                                  empty,
   input  logic                                  pop,
   output logic                                  rsp_hit,
   output logic [cmfu_pkg::SLOT_W-1:0]           rsp_motor_slot,
   output logic signed [cmfu_pkg::POS_W-1:0]     rsp_position_count,
   output logic signed [cmfu_pkg::WORD_W-1:0]    rsp_speed_raw,
   output logic signed [cmfu_pkg::WORD_W-1:0]    rsp_current_raw,
   output logic [cmfu_pkg::BYTE_W-1:0]           rsp_temperature
);

   localparam int MID_W     = $bits(cmfu_pkg::mid_item_type);
   localparam int RSP_W     = $bits(cmfu_pkg::rsp_item_type);
   localparam int MID_CNT_W = $clog2(cmfu_pkg::MID_DEPTH+1);
   localparam int OUT_CNT_W = $clog2(cmfu_pkg::OUT_DEPTH+1);

   cmfu_pkg::csr_type       cfg_ff, cfg_in;
   cmfu_pkg::req_frame_type frame;
   cmfu_pkg::mid_item_type  front_item;
   cmfu_pkg::mid_item_type  mid_data;
   cmfu_pkg::rsp_item_type  back_data;
   cmfu_pkg::rsp_item_type  rsp_data;
   logic                    mid_full, mid_empty, mid_pop;
   logic [MID_CNT_W-1:0]    mid_count;
   logic                    out_push, out_full;
   logic [OUT_CNT_W-1:0]    out_count;

   // Configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (cmfu_pkg::csr_index_type'(csr_index))
            cmfu_pkg::CSR_BASE_ID: cfg_in.motor_base_id     = csr_wdata[cmfu_pkg::ID_W-1:0];
            cmfu_pkg::CSR_ENABLE:  cfg_in.motor_enable_mask = csr_wdata[cmfu_pkg::MASK_W-1:0];
            cmfu_pkg::CSR_CPT:     cfg_in.counts_per_turn   = csr_wdata;
            cmfu_pkg::CSR_WRAP:    cfg_in.wrap_threshold    = csr_wdata;
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.motor_base_id     <= cmfu_pkg::BASE_ID_RESET;
         cfg_ff.motor_enable_mask <= cmfu_pkg::ENABLE_RESET;
         cfg_ff.counts_per_turn   <= cmfu_pkg::CPT_RESET;
         cfg_ff.wrap_threshold    <= cmfu_pkg::WRAP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign frame.frame_id   = req_frame_id;
   assign frame.byte_zero  = req_byte_zero;
   assign frame.byte_one   = req_byte_one;
   assign frame.byte_two   = req_byte_two;
   assign frame.byte_three = req_byte_three;
   assign frame.byte_four  = req_byte_four;
   assign frame.byte_five  = req_byte_five;
   assign frame.byte_six   = req_byte_six;

   cmfu_front #(
      .MOTOR_SLOTS (MOTOR_SLOTS)
   ) u_front (
      .cfg   (cfg_ff),
      .frame (frame),
      .item  (front_item)
   );

   cmfu_fifo #(
      .WIDTH (MID_W),
      .DEPTH (cmfu_pkg::MID_DEPTH)
   ) u_mid_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wr_data (front_item),
      .pop     (mid_pop),
      .rd_data (mid_data),
      .full    (mid_full),
      .empty   (mid_empty),
      .count   (mid_count)
   );

   assign full = mid_full;

   cmfu_back #(
      .MOTOR_SLOTS (MOTOR_SLOTS),
      .TURN_BITS   (TURN_BITS),
      .OUT_DEPTH   (cmfu_pkg::OUT_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .mid_data  (mid_data),
      .mid_empty (mid_empty),
      .mid_pop   (mid_pop),
      .out_count (out_count),
      .out_push  (out_push),
      .out_data  (back_data)
   );

   cmfu_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (cmfu_pkg::OUT_DEPTH)
   ) u_out_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (out_push),
      .wr_data (back_data),
      .pop     (pop),
      .rd_data (rsp_data),
      .full    (out_full),
      .empty   (empty),
      .count   (out_count)
   );

   assign rsp_hit            = rsp_data.hit;
   assign rsp_motor_slot     = rsp_data.motor_slot;
   assign rsp_position_count = rsp_data.position_count;
   assign rsp_speed_raw      = rsp_data.speed_raw;
   assign rsp_current_raw    = rsp_data.current_raw;
   assign rsp_temperature    = rsp_data.temperature;

   // The back end's credit check must keep the result queue from overflowing
   `ASSERT_RST(a_out_no_overflow, clock, reset, out_push |-> !out_full)
   // Mid queue occupancy tracks its empty and full flags
   `ASSERT_RST(a_mid_count_flags, clock, reset, (mid_count == '0) == mid_empty && (mid_count == MID_CNT_W'(cmfu_pkg::MID_DEPTH)) == mid_full)
   // A missed frame carries an all-zero result
   `ASSERT_RST(a_miss_zero, clock, reset, (!empty && !rsp_hit) |-> (rsp_position_count == 0 && rsp_motor_slot == 0 && rsp_temperature == 0))
   // Both queues come out of reset empty
   `ASSERT_ALWAYS(a_reset_empty, clock, reset |=> (empty && !full && !mid_pop))

endmodule

[rtl/cmfu_fifo.sv]
// Small register queue with first-word fall-through read, used on both sides of the back end.
// Depends on nothing; DEPTH must be a power of two.
module cmfu_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  logic [WIDTH-1:0]             wr_data,
   input  logic                         pop,
   output logic [WIDTH-1:0]             rd_data,
   output logic                         full,
   output logic                         empty,
   output logic [$clog2(DEPTH+1)-1:0]   count
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH+1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_wr, do_rd;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign count   = count_ff;
   assign rd_data = slot_ff[rd_ptr_ff];

   assign do_wr = push && !full;
   assign do_rd = pop && !empty;

   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

[rtl/cmfu_front.sv]
// Front end: matches the frame identifier against the enabled motor slots and unpacks the payload.
// Depends on cmfu_pkg.
module cmfu_front #(
   parameter int MOTOR_SLOTS = cmfu_pkg::MOTOR_SLOTS_DEFAULT
) (
   input  cmfu_pkg::csr_type       cfg,
   input  cmfu_pkg::req_frame_type frame,
   output cmfu_pkg::mid_item_type  item
);

   // Slots beyond the enable mask can never match
   localparam int ACTIVE_SLOTS =
      (MOTOR_SLOTS < cmfu_pkg::MASK_W) ? MOTOR_SLOTS : cmfu_pkg::MASK_W;
   localparam int DIFF_W = cmfu_pkg::ID_W + 1;

   logic [DIFF_W-1:0]           id_diff;
   logic                        in_range;
   logic [cmfu_pkg::SLOT_W-1:0] slot;
   logic                        hit;

   assign id_diff  = {1'b0, frame.frame_id} - {1'b0, cfg.motor_base_id};
   // Borrow out means the identifier lies below the base
   assign in_range = !id_diff[DIFF_W-1] && (id_diff < DIFF_W'(ACTIVE_SLOTS));
   assign slot     = id_diff[cmfu_pkg::SLOT_W-1:0];
   assign hit      = in_range && cfg.motor_enable_mask[slot];

   always_comb begin
      item = '0;
      if (hit) begin
         item.hit         = 1'b1;
         item.slot        = slot;
         item.angle       = {frame.byte_zero, frame.byte_one};
         item.speed       = $signed({frame.byte_two, frame.byte_three});
         item.current     = $signed({frame.byte_four, frame.byte_five});
         item.temperature = frame.byte_six;
      end
   end

endmodule

[rtl/cmfu_back.sv]
// Back end: per-slot turn tracking, position multiply and saturation into the result queue.
// Depends on cmfu_pkg.
module cmfu_back #(
   parameter int MOTOR_SLOTS = cmfu_pkg::MOTOR_SLOTS_DEFAULT,
   parameter int TURN_BITS   = cmfu_pkg::TURN_BITS_DEFAULT,
   parameter int OUT_DEPTH   = cmfu_pkg::OUT_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  cmfu_pkg::csr_type              cfg,
   input  cmfu_pkg::mid_item_type         mid_data,
   input  logic                           mid_empty,
   output logic                           mid_pop,
   input  logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
   output logic                           out_push,
   output cmfu_pkg::rsp_item_type         out_data
);

   localparam int ACTIVE_SLOTS =
      (MOTOR_SLOTS < cmfu_pkg::MASK_W) ? MOTOR_SLOTS : cmfu_pkg::MASK_W;
   localparam int CNT_W   = $clog2(OUT_DEPTH+1);
   localparam int WORD_W  = cmfu_pkg::WORD_W;
   localparam int POS_W   = cmfu_pkg::POS_W;
   localparam int PROD_W  = TURN_BITS + WORD_W + 1;
   localparam int SUM_W   = (PROD_W + 1 > POS_W + 1) ? PROD_W + 1 : POS_W + 1;

   localparam logic signed [TURN_BITS-1:0] TURN_MAX = {1'b0, {(TURN_BITS-1){1'b1}}};
   localparam logic signed [TURN_BITS-1:0] TURN_MIN = {1'b1, {(TURN_BITS-1){1'b0}}};
   localparam logic signed [SUM_W-1:0] POS_MAX = SUM_W'($signed(32'h7FFF_FFFF));
   localparam logic signed [SUM_W-1:0] POS_MIN = SUM_W'($signed(32'h8000_0000));

   // Per-slot state
   logic [WORD_W-1:0]           last_angle_ff [ACTIVE_SLOTS];
   logic signed [TURN_BITS-1:0] turn_ff       [ACTIVE_SLOTS];
   logic [ACTIVE_SLOTS-1:0]     seen_ff;

   logic [ACTIVE_SLOTS-1:0]     sel;
   logic [WORD_W-1:0]           rd_last;
   logic signed [TURN_BITS-1:0] rd_turn;
   logic                        rd_seen;
   logic signed [WORD_W:0]      angle_diff;
   logic signed [WORD_W:0]      thr_pos;
   logic signed [WORD_W:0]      thr_neg;
   logic signed [TURN_BITS-1:0] turn_next;

   // Pipeline registers
   logic                          s1_valid_ff;
   cmfu_pkg::mid_item_type        s1_item_ff;
   logic signed [TURN_BITS-1:0]   s1_turn_ff, s1_turn_in;
   logic                          s2_valid_ff;
   cmfu_pkg::mid_item_type        s2_item_ff;
   logic signed [PROD_W-1:0]      s2_prod_ff, s2_prod_in;

   logic [CNT_W:0]                in_flight;
   logic signed [SUM_W-1:0]       pos_sum;
   logic signed [POS_W-1:0]       pos_sat;

   // Hold the queue while the result side could overflow
   assign in_flight = {1'b0, out_count} + (CNT_W+1)'(s1_valid_ff) + (CNT_W+1)'(s2_valid_ff);
   assign mid_pop   = !mid_empty && (in_flight < (CNT_W+1)'(OUT_DEPTH));

   always_comb begin
      rd_last = '0;
      rd_turn = '0;
      rd_seen = 1'b0;
      for (int s = 0; s < ACTIVE_SLOTS; s++) begin
         sel[s] = mid_data.hit && (mid_data.slot == cmfu_pkg::SLOT_W'(s));
         if (sel[s]) begin
            rd_last = last_angle_ff[s];
            rd_turn = turn_ff[s];
            rd_seen = seen_ff[s];
         end
      end
   end

   assign angle_diff = $signed({1'b0, mid_data.angle}) - $signed({1'b0, rd_last});
   assign thr_pos    = $signed({1'b0, cfg.wrap_threshold});
   assign thr_neg    = -thr_pos;

   always_comb begin
      turn_next = rd_turn;
      if (rd_seen) begin
         if (angle_diff > thr_pos) begin
            if (rd_turn != TURN_MIN) begin
               turn_next = rd_turn - 1'b1;
            end
         end else if (angle_diff < thr_neg) begin
            if (rd_turn != TURN_MAX) begin
               turn_next = rd_turn + 1'b1;
            end
         end
      end
      s1_turn_in = mid_data.hit ? turn_next : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
         for (int s = 0; s < ACTIVE_SLOTS; s++) begin
            last_angle_ff[s] <= '0;
            turn_ff[s]       <= '0;
         end
      end else if (mid_pop) begin
         for (int s = 0; s < ACTIVE_SLOTS; s++) begin
            if (sel[s]) begin
               last_angle_ff[s] <= mid_data.angle;
               turn_ff[s]       <= turn_next;
               seen_ff[s]       <= 1'b1;
            end
         end
      end
   end

   assign s2_prod_in = PROD_W'(s1_turn_ff) * PROD_W'($signed({1'b0, cfg.counts_per_turn}));

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= mid_pop;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff <= mid_data;
      s1_turn_ff <= s1_turn_in;
      s2_item_ff <= s1_item_ff;
      s2_prod_ff <= s2_prod_in;
   end

   assign pos_sum = SUM_W'(s2_prod_ff) + SUM_W'($signed({1'b0, s2_item_ff.angle}));

   always_comb begin
      if (pos_sum > POS_MAX) begin
         pos_sat = POS_MAX[POS_W-1:0];
      end else if (pos_sum < POS_MIN) begin
         pos_sat = POS_MIN[POS_W-1:0];
      end else begin
         pos_sat = pos_sum[POS_W-1:0];
      end
   end

   assign out_push                = s2_valid_ff;
   assign out_data.hit            = s2_item_ff.hit;
   assign out_data.motor_slot     = s2_item_ff.slot;
   assign out_data.position_count = pos_sat;
   assign out_data.speed_raw      = s2_item_ff.speed;
   assign out_data.current_raw    = s2_item_ff.current;
   assign out_data.temperature    = s2_item_ff.temperature;

endmodule
